@@ design/hop_pkg.sv @@
package hop_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned LenW  = 24;

  localparam logic [WordW-1:0] BLK_HEADER   = 32'h0000_03f3;
  localparam logic [WordW-1:0] BLK_BSS      = 32'h0000_03eb;
  localparam logic [WordW-1:0] BLK_DEBUG    = 32'h0000_03f1;
  localparam logic [WordW-1:0] BLK_END      = 32'h0000_03f2;
  localparam logic [WordW-1:0] BLK_NAME     = 32'h0000_03e8;
  localparam logic [WordW-1:0] BLK_CODE     = 32'h0000_03e9;
  localparam logic [WordW-1:0] BLK_DATA     = 32'h0000_03ea;
  localparam logic [WordW-1:0] BLK_RELOC16A = 32'h0000_03cd;
  localparam logic [WordW-1:0] BLK_RELOC32A = 32'h0000_03cc;
  localparam logic [WordW-1:0] BLK_RELOC16B = 32'h0000_03ed;
  localparam logic [WordW-1:0] BLK_RELOC32B = 32'h0000_03ec;
  localparam logic [WordW-1:0] BLK_SYMBOL   = 32'h0000_03f0;
  localparam logic [WordW-1:0] BLK_UNIT     = 32'h0000_03e7;
  localparam logic [WordW-1:0] BLK_EXT      = 32'h0000_03ef;

  typedef enum logic [3:0] {
    CODE_HEADER   = 4'd0,
    CODE_BSS      = 4'd1,
    CODE_DEBUG    = 4'd2,
    CODE_END      = 4'd3,
    CODE_NAME     = 4'd4,
    CODE_CODE     = 4'd5,
    CODE_DATA     = 4'd6,
    CODE_RELOC16A = 4'd7,
    CODE_RELOC32A = 4'd8,
    CODE_RELOC16B = 4'd9,
    CODE_RELOC32B = 4'd10,
    CODE_SYMBOL   = 4'd11,
    CODE_UNIT     = 4'd12,
    CODE_EXT      = 4'd13,
    CODE_UNKNOWN  = 4'd14
  } hop_code_e;

  typedef enum logic [4:0] {
    KIND_BLOCK_TYPE = 5'd0,
    KIND_NAME_LEN   = 5'd1,
    KIND_NAME_WORD  = 5'd2,
    KIND_LENGTH     = 5'd3,
    KIND_DATA_WORD  = 5'd4,
    KIND_TABLE_SIZE = 5'd5,
    KIND_FIRST      = 5'd6,
    KIND_LAST       = 5'd7,
    KIND_HUNK_SIZE  = 5'd8,
    KIND_RELOC_CNT  = 5'd9,
    KIND_RELOC_TGT  = 5'd10,
    KIND_RELOC_OFF  = 5'd11,
    KIND_SYM_VALUE  = 5'd12,
    KIND_EXT_ENTRY  = 5'd13,
    KIND_EXT_VALUE  = 5'd14,
    KIND_REF_CNT    = 5'd15,
    KIND_LIST_END   = 5'd16,
    KIND_ERROR      = 5'd17
  } hop_kind_e;

  typedef struct packed {
    hop_kind_e        kind;
    hop_code_e        code;
    logic [7:0]       ext_type;
    logic [WordW-1:0] value;
    logic             error;
  } hop_result_t;

endpackage

@@ design/hop_parser.sv @@
module hop_parser
  import hop_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [WordW-1:0]  word_i,
  output hop_result_t       result_o
);

  typedef enum logic [4:0] {
    S_TYPE, S_HNLEN, S_HNWORD, S_HTAB, S_HFIRST, S_HLAST, S_HSIZE,
    S_BSSLEN, S_DLEN, S_DWORD, S_NLEN, S_NWORD, S_RCNT, S_RTGT, S_ROFF,
    S_SNLEN, S_SNWORD, S_SVAL, S_XENT, S_XNWORD, S_XVAL1, S_XVAL,
    S_XRCNT, S_XRWORD, S_ERR
  } state_e;

  state_e            state_q, state_d;
  logic [LenW-1:0]   left_q, left_d;
  hop_code_e         code_q, code_d;
  logic [LenW-1:0]   first_q, first_d;
  logic [7:0]        ext_q, ext_d;
  logic              err_q, err_d;

  logic [LenW-1:0]   len;
  logic [LenW-1:0]   left_dec;
  logic              left_done;
  logic              word_zero;
  hop_code_e         dec_code;
  hop_kind_e         kind;
  logic [WordW-1:0]  value;

  function automatic state_e ext_next(input logic [7:0] t);
    state_e s;
    if (t == 8'd1 || t == 8'd2 || t == 8'd3) begin
      s = S_XVAL1;
    end else if (t[7]) begin
      s = S_XRCNT;
    end else begin
      s = S_XVAL;
    end
    return s;
  endfunction

  function automatic state_e code_state(input hop_code_e c);
    state_e s;
    case (c)
      CODE_HEADER:                           s = S_HNLEN;
      CODE_BSS:                              s = S_BSSLEN;
      CODE_DEBUG, CODE_CODE, CODE_DATA:      s = S_DLEN;
      CODE_NAME, CODE_UNIT:                  s = S_NLEN;
      CODE_RELOC16A, CODE_RELOC32A,
      CODE_RELOC16B, CODE_RELOC32B:          s = S_RCNT;
      CODE_SYMBOL:                           s = S_SNLEN;
      CODE_EXT:                              s = S_XENT;
      default:                               s = S_TYPE;
    endcase
    return s;
  endfunction

  assign len       = word_i[LenW-1:0];
  assign word_zero = (word_i == '0);
  assign left_dec  = (left_q != '0) ? left_q - LenW'(1) : '0;
  assign left_done = (left_dec == '0);

  always_comb begin
    case (word_i)
      BLK_HEADER:   dec_code = CODE_HEADER;
      BLK_BSS:      dec_code = CODE_BSS;
      BLK_DEBUG:    dec_code = CODE_DEBUG;
      BLK_END:      dec_code = CODE_END;
      BLK_NAME:     dec_code = CODE_NAME;
      BLK_CODE:     dec_code = CODE_CODE;
      BLK_DATA:     dec_code = CODE_DATA;
      BLK_RELOC16A: dec_code = CODE_RELOC16A;
      BLK_RELOC32A: dec_code = CODE_RELOC32A;
      BLK_RELOC16B: dec_code = CODE_RELOC16B;
      BLK_RELOC32B: dec_code = CODE_RELOC32B;
      BLK_SYMBOL:   dec_code = CODE_SYMBOL;
      BLK_UNIT:     dec_code = CODE_UNIT;
      BLK_EXT:      dec_code = CODE_EXT;
      default:      dec_code = CODE_UNKNOWN;
    endcase
  end

  always_comb begin
    state_d = state_q;
    left_d  = left_q;
    code_d  = code_q;
    first_d = first_q;
    ext_d   = ext_q;
    err_d   = err_q;
    kind    = KIND_ERROR;
    value   = word_i;
    case (state_q)
      S_TYPE: begin
        code_d = dec_code;
        if (dec_code == CODE_UNKNOWN) begin
          err_d   = 1'b1;
          state_d = S_ERR;
        end else begin
          kind    = KIND_BLOCK_TYPE;
          state_d = code_state(dec_code);
        end
      end
      S_HNLEN: begin
        if (word_zero) begin
          kind    = KIND_LIST_END;
          state_d = S_HTAB;
        end else begin
          kind    = KIND_NAME_LEN;
          value   = WordW'(len);
          left_d  = len;
          state_d = (len != '0) ? S_HNWORD : S_HNLEN;
        end
      end
      S_HNWORD: begin
        kind    = KIND_NAME_WORD;
        left_d  = left_dec;
        state_d = left_done ? S_HNLEN : S_HNWORD;
      end
      S_HTAB: begin
        kind    = KIND_TABLE_SIZE;
        state_d = S_HFIRST;
      end
      S_HFIRST: begin
        kind    = KIND_FIRST;
        first_d = len;
        state_d = S_HLAST;
      end
      S_HLAST: begin
        kind    = KIND_LAST;
        left_d  = len - first_q + LenW'(1);
        state_d = (left_d != '0) ? S_HSIZE : S_TYPE;
      end
      S_HSIZE: begin
        kind    = KIND_HUNK_SIZE;
        left_d  = left_dec;
        state_d = left_done ? S_TYPE : S_HSIZE;
      end
      S_BSSLEN: begin
        kind    = KIND_LENGTH;
        value   = WordW'(len);
        state_d = S_TYPE;
      end
      S_DLEN: begin
        kind    = KIND_LENGTH;
        value   = WordW'(len);
        left_d  = len;
        state_d = (len != '0) ? S_DWORD : S_TYPE;
      end
      S_DWORD: begin
        kind    = KIND_DATA_WORD;
        left_d  = left_dec;
        state_d = left_done ? S_TYPE : S_DWORD;
      end
      S_NLEN: begin
        kind    = KIND_NAME_LEN;
        value   = WordW'(len);
        left_d  = len;
        state_d = (len != '0) ? S_NWORD : S_TYPE;
      end
      S_NWORD: begin
        kind    = KIND_NAME_WORD;
        left_d  = left_dec;
        state_d = left_done ? S_TYPE : S_NWORD;
      end
      S_RCNT: begin
        if (word_zero) begin
          kind    = KIND_LIST_END;
          state_d = S_TYPE;
        end else begin
          kind    = KIND_RELOC_CNT;
          value   = WordW'(len);
          left_d  = len;
          state_d = S_RTGT;
        end
      end
      S_RTGT: begin
        kind    = KIND_RELOC_TGT;
        state_d = (left_q != '0) ? S_ROFF : S_RCNT;
      end
      S_ROFF: begin
        kind    = KIND_RELOC_OFF;
        left_d  = left_dec;
        state_d = left_done ? S_RCNT : S_ROFF;
      end
      S_SNLEN: begin
        if (word_zero) begin
          kind    = KIND_LIST_END;
          state_d = S_TYPE;
        end else begin
          kind    = KIND_NAME_LEN;
          value   = WordW'(len);
          left_d  = len;
          state_d = (len != '0) ? S_SNWORD : S_SVAL;
        end
      end
      S_SNWORD: begin
        kind    = KIND_NAME_WORD;
        left_d  = left_dec;
        state_d = left_done ? S_SVAL : S_SNWORD;
      end
      S_SVAL: begin
        kind    = KIND_SYM_VALUE;
        state_d = S_SNLEN;
      end
      S_XENT: begin
        if (word_zero) begin
          kind    = KIND_LIST_END;
          state_d = S_TYPE;
        end else begin
          kind    = KIND_EXT_ENTRY;
          ext_d   = word_i[WordW-1:LenW];
          left_d  = len;
          state_d = (len != '0) ? S_XNWORD : ext_next(word_i[WordW-1:LenW]);
        end
      end
      S_XNWORD: begin
        kind    = KIND_NAME_WORD;
        left_d  = left_dec;
        state_d = left_done ? ext_next(ext_q) : S_XNWORD;
      end
      S_XVAL1: begin
        kind    = KIND_EXT_VALUE;
        state_d = S_XENT;
      end
      S_XVAL: begin
        kind    = KIND_EXT_VALUE;
        state_d = S_XRCNT;
      end
      S_XRCNT: begin
        kind    = KIND_REF_CNT;
        value   = WordW'(len);
        left_d  = len;
        state_d = (len != '0) ? S_XRWORD : S_XENT;
      end
      S_XRWORD: begin
        kind    = KIND_DATA_WORD;
        left_d  = left_dec;
        state_d = left_done ? S_XENT : S_XRWORD;
      end
      default: begin
        state_d = S_ERR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_TYPE;
      left_q  <= '0;
      code_q  <= CODE_HEADER;
      first_q <= '0;
      ext_q   <= '0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      left_q  <= left_d;
      code_q  <= code_d;
      first_q <= first_d;
      ext_q   <= ext_d;
      err_q   <= err_d;
    end
  end

  assign result_o.kind     = kind;
  assign result_o.code     = code_d;
  assign result_o.ext_type = ext_d;
  assign result_o.value    = value;
  assign result_o.error    = err_d;

`ifndef ASSERT_OFF
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("error flag cleared");

  a_err_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ERR) |-> (err_q && code_q == CODE_UNKNOWN))
    else $error("error state without error flag");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DWORD || state_q == S_NWORD || state_q == S_HSIZE ||
     state_q == S_ROFF || state_q == S_HNWORD || state_q == S_SNWORD ||
     state_q == S_XRWORD) |-> (left_q != '0))
    else $error("word run with zero count");
`endif

endmodule

@@ design/hunk_object_word_parser.sv @@
// Hunk object word tagger: takes one assembled 32-bit stream word per transaction and returns
// one tagged result per word (kind, block code, current external type, value with lengths and
// counts cut to 24 bits, sticky error). One word is accepted every cycle unless the input stalls; the
// parse logic sits between the input register and the result register, so each word is held in the
// input register and its result is registered in the result register. The input stalls only while
// both registers are full and the output is stalled. An unknown block type locks the parser in
// its error state until reset.
module hunk_object_word_parser
  import hop_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [WordW-1:0]  word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [4:0]        word_kind_o,
  output logic [3:0]        block_code_o,
  output logic [7:0]        ext_type_o,
  output logic [WordW-1:0]  field_value_o,
  output logic              error_o
);

  logic              in_valid_q;
  logic [WordW-1:0]  in_word_q;
  logic              out_valid_q;
  hop_result_t       res_q;
  hop_result_t       res;
  logic              advance;
  logic              accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  hop_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .word_i   (in_word_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= word_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign word_kind_o   = res_q.kind;
  assign block_code_o  = res_q.code;
  assign ext_type_o    = res_q.ext_type;
  assign field_value_o = res_q.value;
  assign error_o       = res_q.error;

`ifndef ASSERT_OFF
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with room downstream");

  a_error_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && word_kind_o == KIND_ERROR) |-> error_o)
    else $error("error transaction without error flag");

  a_err_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && block_code_o == CODE_UNKNOWN) |-> error_o)
    else $error("unknown block code without error flag");
`endif

endmodule

@@ tb/sv/hunk_object_word_parser_tb.sv @@
`timescale 1ns / 100ps

module hunk_object_word_parser_tb;
  import hop_pkg::*;

  localparam int unsigned NumWords   = 950;
  localparam int unsigned NoiseWords = 60;
  localparam int unsigned PhaseLen   = 120;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned MaxReports = 10;

  typedef enum logic [4:0] {
    ST_TYPE, ST_HDR_NAME_LEN, ST_HDR_NAME_WORD, ST_HDR_TABLE, ST_HDR_FIRST, ST_HDR_LAST,
    ST_HDR_SIZE, ST_BSS_LEN, ST_DATA_LEN, ST_DATA_WORD, ST_NAME_LEN, ST_NAME_WORD,
    ST_RELOC_CNT, ST_RELOC_TGT, ST_RELOC_OFF, ST_SYM_LEN, ST_SYM_WORD, ST_SYM_VAL,
    ST_EXT_ENTRY, ST_EXT_NAME, ST_EXT_VAL1, ST_EXT_VAL, ST_EXT_REFS, ST_EXT_REF_WORD,
    ST_LOCKED
  } parse_state_e;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic [WordW-1:0] in_word;
  logic             out_stall;
  logic             in_stall;
  logic             out_valid;
  logic [4:0]       word_kind;
  logic [3:0]       block_code;
  logic [7:0]       ext_type;
  logic [WordW-1:0] field_value;
  logic             error_flag;

  logic [WordW-1:0]  stream_q[$];
  hop_result_t       tagged_q[$];
  logic              in_taken;
  int unsigned       words_in;
  int unsigned       results_checked;
  int unsigned       mismatches;
  int unsigned       quiet_cycles;
  int unsigned       error_results;
  bit                kinds_seen [18];

  // tagger state
  parse_state_e      pst;
  logic [WordW-1:0]  remain;
  hop_code_e         cur_code;
  logic [WordW-1:0]  hdr_first;
  logic [7:0]        cur_ext;
  logic              sticky_err;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  hunk_object_word_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .word_i        (in_word),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .word_kind_o   (word_kind),
    .block_code_o  (block_code),
    .ext_type_o    (ext_type),
    .field_value_o (field_value),
    .error_o       (error_flag)
  );

  always #2 clk_i = ~clk_i;

  function automatic hop_code_e decode_block(logic [WordW-1:0] w);
    case (w)
      BLK_HEADER:   return CODE_HEADER;
      BLK_BSS:      return CODE_BSS;
      BLK_DEBUG:    return CODE_DEBUG;
      BLK_END:      return CODE_END;
      BLK_NAME:     return CODE_NAME;
      BLK_CODE:     return CODE_CODE;
      BLK_DATA:     return CODE_DATA;
      BLK_RELOC16A: return CODE_RELOC16A;
      BLK_RELOC32A: return CODE_RELOC32A;
      BLK_RELOC16B: return CODE_RELOC16B;
      BLK_RELOC32B: return CODE_RELOC32B;
      BLK_SYMBOL:   return CODE_SYMBOL;
      BLK_UNIT:     return CODE_UNIT;
      BLK_EXT:      return CODE_EXT;
      default:      return CODE_UNKNOWN;
    endcase
  endfunction

  function automatic parse_state_e block_entry(hop_code_e c);
    case (c)
      CODE_HEADER:                              return ST_HDR_NAME_LEN;
      CODE_BSS:                                 return ST_BSS_LEN;
      CODE_DEBUG, CODE_CODE, CODE_DATA:         return ST_DATA_LEN;
      CODE_NAME, CODE_UNIT:                     return ST_NAME_LEN;
      CODE_RELOC16A, CODE_RELOC32A,
      CODE_RELOC16B, CODE_RELOC32B:             return ST_RELOC_CNT;
      CODE_SYMBOL:                              return ST_SYM_LEN;
      CODE_EXT:                                 return ST_EXT_ENTRY;
      default:                                  return ST_TYPE;
    endcase
  endfunction

  function automatic parse_state_e ext_after_name();
    if (cur_ext == 8'd1 || cur_ext == 8'd2 || cur_ext == 8'd3) return ST_EXT_VAL1;
    if (cur_ext[7]) return ST_EXT_REFS;
    return ST_EXT_VAL;
  endfunction

  function automatic parse_state_e run_step(parse_state_e done_st, parse_state_e stay_st);
    if (remain != 0) remain = remain - 1;
    return (remain == 0) ? done_st : stay_st;
  endfunction

  function automatic hop_result_t tag_word(logic [WordW-1:0] w);
    logic [WordW-1:0] m;
    hop_result_t      r;
    parse_state_e     nx;
    m = {8'h00, w[LenW-1:0]};
    r.kind = KIND_ERROR;
    r.value = w;
    nx = pst;
    case (pst)
      ST_TYPE: begin
        cur_code = decode_block(w);
        if (cur_code == CODE_UNKNOWN) begin
          sticky_err = 1'b1;
          nx = ST_LOCKED;
        end else begin
          r.kind = KIND_BLOCK_TYPE;
          nx = block_entry(cur_code);
        end
      end
      ST_HDR_NAME_LEN: begin
        if (w == 0) begin
          r.kind = KIND_LIST_END;
          nx = ST_HDR_TABLE;
        end else begin
          r.kind = KIND_NAME_LEN;
          r.value = m;
          remain = m;
          nx = (m != 0) ? ST_HDR_NAME_WORD : ST_HDR_NAME_LEN;
        end
      end
      ST_HDR_NAME_WORD: begin
        r.kind = KIND_NAME_WORD;
        nx = run_step(ST_HDR_NAME_LEN, ST_HDR_NAME_WORD);
      end
      ST_HDR_TABLE: begin
        r.kind = KIND_TABLE_SIZE;
        nx = ST_HDR_FIRST;
      end
      ST_HDR_FIRST: begin
        r.kind = KIND_FIRST;
        hdr_first = w;
        nx = ST_HDR_LAST;
      end
      ST_HDR_LAST: begin
        r.kind = KIND_LAST;
        remain = (w - hdr_first + 32'd1) & 32'h00ff_ffff;
        nx = (remain != 0) ? ST_HDR_SIZE : ST_TYPE;
      end
      ST_HDR_SIZE: begin
        r.kind = KIND_HUNK_SIZE;
        nx = run_step(ST_TYPE, ST_HDR_SIZE);
      end
      ST_BSS_LEN: begin
        r.kind = KIND_LENGTH;
        r.value = m;
        nx = ST_TYPE;
      end
      ST_DATA_LEN: begin
        r.kind = KIND_LENGTH;
        r.value = m;
        remain = m;
        nx = (m != 0) ? ST_DATA_WORD : ST_TYPE;
      end
      ST_DATA_WORD: begin
        r.kind = KIND_DATA_WORD;
        nx = run_step(ST_TYPE, ST_DATA_WORD);
      end
      ST_NAME_LEN: begin
        r.kind = KIND_NAME_LEN;
        r.value = m;
        remain = m;
        nx = (m != 0) ? ST_NAME_WORD : ST_TYPE;
      end
      ST_NAME_WORD: begin
        r.kind = KIND_NAME_WORD;
        nx = run_step(ST_TYPE, ST_NAME_WORD);
      end
      ST_RELOC_CNT: begin
        if (w == 0) begin
          r.kind = KIND_LIST_END;
          nx = ST_TYPE;
        end else begin
          r.kind = KIND_RELOC_CNT;
          r.value = m;
          remain = m;
          nx = ST_RELOC_TGT;
        end
      end
      ST_RELOC_TGT: begin
        r.kind = KIND_RELOC_TGT;
        nx = (remain != 0) ? ST_RELOC_OFF : ST_RELOC_CNT;
      end
      ST_RELOC_OFF: begin
        r.kind = KIND_RELOC_OFF;
        nx = run_step(ST_RELOC_CNT, ST_RELOC_OFF);
      end
      ST_SYM_LEN: begin
        if (w == 0) begin
          r.kind = KIND_LIST_END;
          nx = ST_TYPE;
        end else begin
          r.kind = KIND_NAME_LEN;
          r.value = m;
          remain = m;
          nx = (m != 0) ? ST_SYM_WORD : ST_SYM_VAL;
        end
      end
      ST_SYM_WORD: begin
        r.kind = KIND_NAME_WORD;
        nx = run_step(ST_SYM_VAL, ST_SYM_WORD);
      end
      ST_SYM_VAL: begin
        r.kind = KIND_SYM_VALUE;
        nx = ST_SYM_LEN;
      end
      ST_EXT_ENTRY: begin
        if (w == 0) begin
          r.kind = KIND_LIST_END;
          nx = ST_TYPE;
        end else begin
          r.kind = KIND_EXT_ENTRY;
          cur_ext = w[31:24];
          remain = m;
          nx = (m != 0) ? ST_EXT_NAME : ext_after_name();
        end
      end
      ST_EXT_NAME: begin
        r.kind = KIND_NAME_WORD;
        if (remain != 0) remain = remain - 1;
        nx = (remain != 0) ? ST_EXT_NAME : ext_after_name();
      end
      ST_EXT_VAL1: begin
        r.kind = KIND_EXT_VALUE;
        nx = ST_EXT_ENTRY;
      end
      ST_EXT_VAL: begin
        r.kind = KIND_EXT_VALUE;
        nx = ST_EXT_REFS;
      end
      ST_EXT_REFS: begin
        r.kind = KIND_REF_CNT;
        r.value = m;
        remain = m;
        nx = (m != 0) ? ST_EXT_REF_WORD : ST_EXT_ENTRY;
      end
      ST_EXT_REF_WORD: begin
        r.kind = KIND_DATA_WORD;
        nx = run_step(ST_EXT_ENTRY, ST_EXT_REF_WORD);
      end
      default: begin
        r.kind = KIND_ERROR;
        nx = ST_LOCKED;
      end
    endcase
    pst = nx;
    r.code = cur_code;
    r.ext_type = cur_ext;
    r.error = sticky_err;
    return r;
  endfunction

  // stream generation

  function automatic logic [WordW-1:0] content_word();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    case (sel)
      0:       return BLK_HEADER;
      1:       return BLK_EXT;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned run_len();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 0;
    if (sel == 9) return $urandom_range(5, 16);
    return $urandom_range(1, 4);
  endfunction

  function automatic logic [WordW-1:0] len_word(int unsigned n, bit nonzero);
    logic [7:0]       hi;
    logic [WordW-1:0] w;
    hi = 8'h00;
    if ($urandom_range(0, 3) == 0) hi = 8'($urandom_range(0, 255));
    w = {hi, n[LenW-1:0]};
    if (nonzero && w == 0) w[24 + $urandom_range(0, 7)] = 1'b1;
    return w;
  endfunction

  task automatic push_run(int unsigned n, bit nonzero);
    stream_q.push_back(len_word(n, nonzero));
    repeat (n) stream_q.push_back(content_word());
  endtask

  task automatic push_ext_entry();
    logic [7:0]       t;
    logic [WordW-1:0] w;
    int unsigned      n;
    int unsigned      sel;
    sel = $urandom_range(0, 5);
    if (sel < 2) t = 8'($urandom_range(1, 3));
    else if (sel < 4) t = {1'b1, 7'($urandom_range(0, 127))};
    else t = {1'b0, 7'($urandom_range(0, 127))};
    n = run_len();
    w = {t, n[LenW-1:0]};
    if (w == 0) w[26] = 1'b1;
    t = w[31:24];
    stream_q.push_back(w);
    repeat (n) stream_q.push_back(content_word());
    if (t == 8'd1 || t == 8'd2 || t == 8'd3) begin
      stream_q.push_back(content_word());
    end else begin
      if (!t[7]) stream_q.push_back(content_word());
      push_run(run_len(), 1'b0);
    end
  endtask

  task automatic push_block();
    logic [WordW-1:0] first;
    int unsigned      n;
    case ($urandom_range(0, 13))
      0: begin
        stream_q.push_back(BLK_HEADER);
        repeat ($urandom_range(0, 2)) push_run(run_len(), 1'b1);
        stream_q.push_back(32'h0);
        stream_q.push_back(content_word());
        first = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 8) : $urandom;
        stream_q.push_back(first);
        if ($urandom_range(0, 9) == 0) begin
          // count wraps to zero in the low 24 bits
          stream_q.push_back(first + 32'h0100_0000 - 32'd1);
        end else begin
          n = $urandom_range(0, 4);
          stream_q.push_back(first + n - 32'd1);
          repeat (n) stream_q.push_back(content_word());
        end
      end
      1: begin
        stream_q.push_back(BLK_BSS);
        stream_q.push_back(content_word());
      end
      2: begin
        stream_q.push_back(BLK_DEBUG);
        push_run(run_len(), 1'b0);
      end
      3: stream_q.push_back(BLK_END);
      4: begin
        stream_q.push_back(BLK_NAME);
        push_run(run_len(), 1'b0);
      end
      5: begin
        stream_q.push_back(BLK_CODE);
        push_run(run_len(), 1'b0);
      end
      6: begin
        stream_q.push_back(BLK_DATA);
        push_run(run_len(), 1'b0);
      end
      7, 8, 9, 10: begin
        case ($urandom_range(0, 3))
          0:       stream_q.push_back(BLK_RELOC16A);
          1:       stream_q.push_back(BLK_RELOC32A);
          2:       stream_q.push_back(BLK_RELOC16B);
          default: stream_q.push_back(BLK_RELOC32B);
        endcase
        repeat ($urandom_range(0, 3)) begin
          n = $urandom_range(0, 3);
          stream_q.push_back(len_word(n, 1'b1));
          stream_q.push_back(content_word());
          repeat (n) stream_q.push_back(content_word());
        end
        stream_q.push_back(32'h0);
      end
      11: begin
        stream_q.push_back(BLK_SYMBOL);
        repeat ($urandom_range(0, 3)) begin
          push_run(run_len(), 1'b1);
          stream_q.push_back(content_word());
        end
        stream_q.push_back(32'h0);
      end
      12: begin
        stream_q.push_back(BLK_UNIT);
        push_run(run_len(), 1'b0);
      end
      default: begin
        stream_q.push_back(BLK_EXT);
        repeat ($urandom_range(0, 3)) push_ext_entry();
        stream_q.push_back(32'h0);
      end
    endcase
  endtask

  // sender and receiver

  always @(posedge clk_i) begin
    in_taken <= in_fire;
    if (in_fire) begin
      tagged_q.push_back(tag_word(in_word));
      words_in <= words_in + 1;
    end
  end

  always @(negedge clk_i) begin
    int unsigned phase;
    int unsigned idle_pct;
    phase = (words_in / PhaseLen) % 4;
    idle_pct = (phase == 1) ? 71 : (phase == 3) ? 7 : 0;
    out_stall <= ((phase == 2) ? ($urandom_range(0, 99) < 71) :
                  (phase == 3) ? ($urandom_range(0, 99) < 7) : 1'b0);
    if (rst_ni && (!in_valid || in_taken)) begin
      if (stream_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_word <= stream_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    hop_result_t exp_r;
    if (out_fire) begin
      if (word_kind < 18) kinds_seen[word_kind] = 1'b1;
      if (error_flag) error_results++;
      if (tagged_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result kind=%0d code=%0d ext=%02h value=%08h err=%0b",
                   $realtime, word_kind, block_code, ext_type, field_value, error_flag);
      end else begin
        exp_r = tagged_q.pop_front();
        results_checked++;
        if (word_kind !== exp_r.kind || block_code !== exp_r.code ||
            ext_type !== exp_r.ext_type || field_value !== exp_r.value ||
            error_flag !== exp_r.error) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("%0t: result %0d mismatch", $realtime, results_checked);
            $display("  expected kind=%0d code=%0d ext=%02h value=%08h err=%0b",
                     exp_r.kind, exp_r.code, exp_r.ext_type, exp_r.value, exp_r.error);
            $display("  actual   kind=%0d code=%0d ext=%02h value=%08h err=%0b",
                     word_kind, block_code, ext_type, field_value, error_flag);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire || out_fire) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles", IdleLimit);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned kinds_hit;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    in_taken = 1'b0;
    words_in = 0;
    results_checked = 0;
    mismatches = 0;
    quiet_cycles = 0;
    error_results = 0;
    pst = ST_TYPE;
    remain = '0;
    cur_code = CODE_HEADER;
    hdr_first = '0;
    cur_ext = 8'h00;
    sticky_err = 1'b0;

    // header with one two-word name and a hunk range that wraps
    stream_q.push_back(BLK_HEADER);
    stream_q.push_back(32'h0000_0002);
    stream_q.push_back(32'hffff_ffff);
    stream_q.push_back(32'h0000_0000);
    stream_q.push_back(32'h0000_0000);
    stream_q.push_back(32'hffff_ffff);
    stream_q.push_back(32'hffff_ffff);
    stream_q.push_back(32'h0000_0000);
    stream_q.push_back(32'h1234_5678);
    stream_q.push_back(32'h8000_0000);
    // length with only high bits set
    stream_q.push_back(BLK_CODE);
    stream_q.push_back(32'hff00_0000);
    // header with empty name and zero hunk count
    stream_q.push_back(BLK_HEADER);
    stream_q.push_back(32'h0100_0000);
    stream_q.push_back(32'h0000_0000);
    stream_q.push_back(32'h0000_0005);
    stream_q.push_back(32'h0000_0007);
    stream_q.push_back(32'h0000_0006);
    // external reference and definition without names
    stream_q.push_back(BLK_EXT);
    stream_q.push_back(32'h8100_0000);
    stream_q.push_back(32'hab00_0001);
    stream_q.push_back(32'haaaa_aaaa);
    stream_q.push_back(32'h0200_0000);
    stream_q.push_back(32'h5555_5555);
    stream_q.push_back(32'h0000_0000);

    while (stream_q.size() < NumWords - NoiseWords) push_block();
    // unknown block type, then noise on the locked parser
    stream_q.push_back(32'h0000_03ee);
    repeat (NoiseWords - 1) stream_q.push_back(content_word());

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (stream_q.size() != 0 || in_valid) @(posedge clk_i);
    while (tagged_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    kinds_hit = 0;
    foreach (kinds_seen[k]) if (kinds_seen[k]) kinds_hit++;
    $display("sent %0d words, checked %0d results, %0d mismatches", words_in,
             results_checked, mismatches);
    $display("%0d of 18 word kinds seen, %0d results with error flag set", kinds_hit,
             error_results);
    if (mismatches == 0 && tagged_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/hop_pkg.sv
design/hop_parser.sv
design/hunk_object_word_parser.sv
tb/sv/hunk_object_word_parser_tb.sv
